### rtl/arpc_pkg.sv
// arpc_pkg: shared types, codes and sizes for the arp cache and responder
package arpc_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_PACKET  = 2'd1;
  localparam logic [1:0] OP_SEND    = 2'd2;

  localparam logic [2:0] KIND_NOTHING = 3'd0;
  localparam logic [2:0] KIND_HIT     = 3'd1;
  localparam logic [2:0] KIND_MISS    = 3'd2;
  localparam logic [2:0] KIND_REPLY   = 3'd3;
  localparam logic [2:0] KIND_REQUEST = 3'd4;

  localparam logic [15:0] ARP_MIN_LEN    = 16'd28;
  localparam logic [15:0] HW_ETHERNET    = 16'h0001;
  localparam logic [15:0] PROTO_IPV4     = 16'h0800;
  localparam logic [15:0] OPCODE_REQUEST = 16'h0001;
  localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;

  localparam logic CFG_OWN_IP  = 1'b0;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] hw_type;
    logic [15:0] ptype;
    logic [15:0] arp_opcode;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] packet_len;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] dest_mac;
    logic [47:0] found_mac;
    logic [31:0] out_ip;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      ip;
    logic [47:0]      mac;
  } tbl_wr_t;

  typedef struct packed {
    logic        hit;
    logic        free;
    logic [47:0] mac;
  } tbl_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

### rtl/arpc_table.sv
// arpc_table: mapping table storage with the single entry compare unit
module arpc_table (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [arpc_pkg::IDX_W-1:0] rd_idx,
  input  logic [31:0]             key,
  input  arpc_pkg::tbl_wr_t       wr,
  output arpc_pkg::tbl_stat_t     stat
);

  logic [arpc_pkg::TABLE_ENTRIES-1:0] valid_r;
  logic [31:0] ip_r  [arpc_pkg::TABLE_ENTRIES];
  logic [47:0] mac_r [arpc_pkg::TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ip_r[wr.idx]  <= wr.ip;
      mac_r[wr.idx] <= wr.mac;
    end
  end

  // one entry compared per cycle
  always_comb begin
    stat.hit  = valid_r[rd_idx] && (ip_r[rd_idx] == key);
    stat.free = !valid_r[rd_idx];
    stat.mac  = mac_r[rd_idx];
  end

endmodule

### rtl/arpc_ctrl.sv
// arpc_ctrl: sequencer that scans the table, inserts mappings and forms results
module arpc_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  arpc_pkg::in_item_t      in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output arpc_pkg::out_item_t     out_data,
  input  logic [31:0]             own_ip,
  output logic [arpc_pkg::IDX_W-1:0] tbl_idx,
  output logic [31:0]             tbl_key,
  output arpc_pkg::tbl_wr_t       tbl_wr,
  input  arpc_pkg::tbl_stat_t     tbl_stat
);

  localparam logic [arpc_pkg::IDX_W-1:0] LAST_IDX =
    arpc_pkg::IDX_W'(arpc_pkg::TABLE_ENTRIES - 1);

  arpc_pkg::state_t state_r, state_nxt;
  logic [arpc_pkg::IDX_W-1:0] idx_r, idx_nxt;
  arpc_pkg::in_item_t item_r;
  logic reply_r;
  logic hit_found_r;
  logic [arpc_pkg::IDX_W-1:0] hit_slot_r;
  logic [47:0] hit_mac_r;
  logic free_found_r;
  logic [arpc_pkg::IDX_W-1:0] free_slot_r;
  arpc_pkg::out_item_t res;
  arpc_pkg::out_item_t out_r;
  logic out_valid_r;

  logic in_xfer;
  logic pkt_ok;
  logic usable;
  logic scan_last;
  logic load;

  assign in_xfer = in_valid && in_ready;
  assign pkt_ok  = (in_data.packet_len >= arpc_pkg::ARP_MIN_LEN) &&
                   (in_data.hw_type == arpc_pkg::HW_ETHERNET) &&
                   (in_data.ptype == arpc_pkg::PROTO_IPV4);
  assign usable  = (in_data.src_ip != 32'd0) && (in_data.src_mac != 48'd0) &&
                   (in_data.src_mac != arpc_pkg::MAC_BCAST);
  assign scan_last = (idx_r == LAST_IDX) || tbl_stat.hit;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arpc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.op == arpc_pkg::OP_LOOKUP) begin
            state_nxt = arpc_pkg::ST_SCAN;
          end else if (in_data.op == arpc_pkg::OP_PACKET && pkt_ok && usable) begin
            state_nxt = arpc_pkg::ST_SCAN;
          end else begin
            state_nxt = arpc_pkg::ST_DONE;
          end
        end
      end
      arpc_pkg::ST_SCAN: begin
        if (scan_last) begin
          if (item_r.op == arpc_pkg::OP_LOOKUP) begin
            state_nxt = arpc_pkg::ST_DONE;
          end else begin
            state_nxt = arpc_pkg::ST_WRITE;
          end
        end
      end
      arpc_pkg::ST_WRITE: begin
        state_nxt = arpc_pkg::ST_DONE;
      end
      arpc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = arpc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = arpc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    idx_nxt  = idx_r;
    tbl_wr.en  = 1'b0;
    tbl_wr.idx = '0;
    tbl_wr.ip  = item_r.src_ip;
    tbl_wr.mac = item_r.src_mac;
    if (hit_found_r) begin
      tbl_wr.idx = hit_slot_r;
    end else if (free_found_r) begin
      tbl_wr.idx = free_slot_r;
    end
    case (state_r)
      arpc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        idx_nxt  = '0;
      end
      arpc_pkg::ST_SCAN: begin
        if (scan_last) begin
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      arpc_pkg::ST_WRITE: begin
        tbl_wr.en = 1'b1;
      end
      arpc_pkg::ST_DONE: begin
        load = !out_valid_r || out_ready;
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  assign tbl_idx = idx_r;
  assign tbl_key = (item_r.op == arpc_pkg::OP_LOOKUP) ? item_r.dst_ip : item_r.src_ip;

  // result formation
  always_comb begin
    res = '0;
    case (item_r.op)
      arpc_pkg::OP_LOOKUP: begin
        res.kind      = hit_found_r ? arpc_pkg::KIND_HIT : arpc_pkg::KIND_MISS;
        res.found_mac = hit_found_r ? hit_mac_r : 48'd0;
        res.out_ip    = item_r.dst_ip;
      end
      arpc_pkg::OP_PACKET: begin
        if (reply_r) begin
          res.kind      = arpc_pkg::KIND_REPLY;
          res.dest_mac  = item_r.src_mac;
          res.found_mac = item_r.src_mac;
          res.out_ip    = item_r.src_ip;
        end
      end
      arpc_pkg::OP_SEND: begin
        res.kind     = arpc_pkg::KIND_REQUEST;
        res.dest_mac = arpc_pkg::MAC_BCAST;
        res.out_ip   = item_r.dst_ip;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arpc_pkg::ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r       <= in_data;
      reply_r      <= (in_data.op == arpc_pkg::OP_PACKET) && pkt_ok &&
                      (in_data.arp_opcode == arpc_pkg::OPCODE_REQUEST) &&
                      (in_data.dst_ip == own_ip);
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (state_r == arpc_pkg::ST_SCAN) begin
      if (tbl_stat.hit) begin
        hit_found_r <= 1'b1;
        hit_slot_r  <= idx_r;
        hit_mac_r   <= tbl_stat.mac;
      end
      if (tbl_stat.free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= idx_r;
      end
    end
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != arpc_pkg::ST_IDLE)
    else $error("sequencer stayed idle after an input transfer");

  a_write_only_packet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == arpc_pkg::ST_WRITE |-> item_r.op == arpc_pkg::OP_PACKET)
    else $error("table write for an item that is not a packet");

  a_idle_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == arpc_pkg::ST_IDLE |-> idx_r == '0)
    else $error("scan index not rewound while idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("pending result overwritten");

endmodule

### rtl/arp_cache_and_responder.sv
// arp_cache_and_responder: top level of the arp cache and responder
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  input   | in_valid, in_ready, in_data    | in
//  result  | out_valid, out_ready, out_data | out
//  config  | cfg_we, cfg_index, cfg_wdata   | in
//
// lookup: idle, a scan of k table entries (stops at the first match, at most TABLE_ENTRIES), done
// usable packet: idle, scan, one table write, done (result); other items go from idle straight to done
// the scan compares one table entry per cycle in the shared compare unit
// reset clears the table valid bits at once; no clearing pass
// a new item is taken while a result waits; a stalled result holds the next one in done
module arp_cache_and_responder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  arpc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output arpc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [47:0]         cfg_wdata
);

  logic [31:0] own_ip_r;
  logic [arpc_pkg::IDX_W-1:0] tbl_idx;
  logic [31:0] tbl_key;
  arpc_pkg::tbl_wr_t   tbl_wr;
  arpc_pkg::tbl_stat_t tbl_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0;
    end else if (cfg_we && cfg_index == {1'b0, arpc_pkg::CFG_OWN_IP}) begin
      own_ip_r <= cfg_wdata[31:0];
    end
  end

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .own_ip    (own_ip_r),
    .tbl_idx   (tbl_idx),
    .tbl_key   (tbl_key),
    .tbl_wr    (tbl_wr),
    .tbl_stat  (tbl_stat)
  );

  arpc_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (tbl_idx),
    .key    (tbl_key),
    .wr     (tbl_wr),
    .stat   (tbl_stat)
  );

endmodule
